>>> rtl/tlcsp_pkg.sv
// ----------------------------------------------------------------------------
// tlcsp_pkg
// shared constants for the two-level cache with stride prefetcher
// ----------------------------------------------------------------------------
package tlcsp_pkg;

  localparam int ADDR_W  = 48;
  localparam int STAMP_W = 64;
  localparam int WB_W    = 5;
  localparam int DEG_W   = 4;

  localparam logic [DEG_W-1:0] DEG_RESET = 4'd2;

  localparam int DEF_L1_SIZE_LOG2  = 15;
  localparam int DEF_L1_BLOCK_LOG2 = 6;
  localparam int DEF_L1_WAYS_LOG2  = 2;
  localparam int DEF_L2_SIZE_LOG2  = 18;
  localparam int DEF_L2_BLOCK_LOG2 = 6;
  localparam int DEF_L2_WAYS_LOG2  = 3;

  // flag bit positions in a line
  localparam int F_VALID = 0;
  localparam int F_DIRTY = 1;
  localparam int F_PREF  = 2;

endpackage

>>> rtl/two_level_cache_stride_prefetch_top.sv
// ----------------------------------------------------------------------------
// two_level_cache_stride_prefetch_top
// two-level write-back lru cache model with a stride prefetcher into l2
// ----------------------------------------------------------------------------
// Each input transaction is one read or write access; the block answers with
// one result transaction (l1/l2 hit, useful prefetch, write-backs, prefetched
// blocks). After reset a clearing pass over max(L1 sets, L2 sets) sets (512 at
// the defaults) zeroes both tag rams; no access is taken meanwhile, config
// writes are. An access then takes one tag set at a time through a single
// compare unit that walks the ways one per cycle: an l1 access loads the l1
// set, scans its ways, updates the set and writes it back; an l1 miss then
// reads, loads, scans, updates and writes back one l2 set per block touched:
// one for a dirty l1 victim, one for the demand block and one per prefetched
// block (up to prefetch_degree). After each result, idle takes the next access.
// ----------------------------------------------------------------------------
module two_level_cache_stride_prefetch_top
  import tlcsp_pkg::*;
#(
  parameter int L1_SIZE_LOG2  = DEF_L1_SIZE_LOG2,
  parameter int L1_BLOCK_LOG2 = DEF_L1_BLOCK_LOG2,
  parameter int L1_WAYS_LOG2  = DEF_L1_WAYS_LOG2,
  parameter int L2_SIZE_LOG2  = DEF_L2_SIZE_LOG2,
  parameter int L2_BLOCK_LOG2 = DEF_L2_BLOCK_LOG2,
  parameter int L2_WAYS_LOG2  = DEF_L2_WAYS_LOG2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DEG_W-1:0]  cfg_data_i,
  // access channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [ADDR_W-1:0] address_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              l1_hit_o,
  output logic              l2_hit_o,
  output logic              prefetch_useful_o,
  output logic [WB_W-1:0]   wb_count_o,
  output logic [DEG_W-1:0]  pf_count_o
);

  // geometry
  localparam int L1_OFF  = L1_SIZE_LOG2 - L1_WAYS_LOG2;
  localparam int L2_OFF  = L2_SIZE_LOG2 - L2_WAYS_LOG2;
  localparam int S1      = L1_OFF - L1_BLOCK_LOG2;
  localparam int S2      = L2_OFF - L2_BLOCK_LOG2;
  localparam int L1_SETS = 1 << S1;
  localparam int L2_SETS = 1 << S2;
  localparam int L1_WAYS = 1 << L1_WAYS_LOG2;
  localparam int L2_WAYS = 1 << L2_WAYS_LOG2;
  localparam int T1      = ADDR_W - L1_OFF;
  localparam int T2      = ADDR_W - L2_OFF;
  localparam int TW      = (T1 > T2) ? T1 : T2;
  localparam int W1      = T1 + 2 + STAMP_W;
  localparam int W2      = T2 + 3 + STAMP_W;
  localparam int WW1     = (L1_WAYS_LOG2 > 0) ? L1_WAYS_LOG2 : 1;
  localparam int WW2     = (L2_WAYS_LOG2 > 0) ? L2_WAYS_LOG2 : 1;
  localparam int WW      = (WW1 > WW2) ? WW1 : WW2;
  localparam int CW      = (S1 > S2) ? S1 : S2;
  localparam int CLR_N   = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_L1_LD, S_L1_SCAN, S_L1_UPD, S_L1_WR,
    S_L2_RD, S_L2_LD, S_L2_SCAN, S_L2_UPD, S_L2_WR, S_DONE
  } state_e;

  typedef enum logic [1:0] {OP_VICTIM, OP_DEMAND, OP_PREF} op_e;

  state_e state_q, after_q;
  op_e    op_q, nxt_op_q;

  logic [CW-1:0]      clr_q;
  logic [DEG_W-1:0]   degree_q;
  logic               wr_q;
  logic [ADDR_W-1:0]  addr_q, l2addr_q, nxt_addr_q;
  logic [STAMP_W-1:0] cnt_q;

  // working copies of the current sets
  logic [T1-1:0]      r1_tag [L1_WAYS];
  logic [1:0]         r1_fl  [L1_WAYS];
  logic [STAMP_W-1:0] r1_st  [L1_WAYS];
  logic [T2-1:0]      r2_tag [L2_WAYS];
  logic [2:0]         r2_fl  [L2_WAYS];
  logic [STAMP_W-1:0] r2_st  [L2_WAYS];

  // scan results
  logic [WW-1:0]      way_q, hitw_q, empw_q, bestw_q;
  logic               hit_q, emp_q, best_dirty_q;
  logic [TW-1:0]      best_tag_q;
  logic [STAMP_W-1:0] best_st_q, minnz_q;
  logic               wen_q;

  // stride detector
  logic [ADDR_W-1:0]  last_q;
  logic               miss_seen_q, stride_known_q;
  logic [ADDR_W:0]    stride_q;
  logic [DEG_W-1:0]   pf_left_q;

  // result accumulation and output register
  logic               res_l1_q, res_l2_q, res_use_q;
  logic [WB_W-1:0]    res_wb_q;
  logic [DEG_W-1:0]   res_pf_q;
  logic               out_valid_q, o_l1_q, o_l2_q, o_use_q;
  logic [WB_W-1:0]    o_wb_q;
  logic [DEG_W-1:0]   o_pf_q;

  logic               accept;
  logic [S1-1:0]      set1;
  logic [T1-1:0]      tag1;
  logic [S2-1:0]      set2;
  logic [T2-1:0]      tag2;
  logic [ADDR_W-1:0]  blk;
  logic [ADDR_W:0]    diff;

  // shared compare unit
  logic [TW-1:0]      cmp_tag_a, cmp_tag_b;
  logic [STAMP_W-1:0] cmp_st;
  logic [1:0]         cmp_fl;
  logic               tag_eq, st_lt_best, st_lt_min;

  // ram ports
  logic               l1_we, l2_we, l2_re;
  logic [S1-1:0]      l1_waddr;
  logic [S2-1:0]      l2_waddr;
  logic [W1*L1_WAYS-1:0] l1_wdata, l1_rdata;
  logic [W2*L2_WAYS-1:0] l2_wdata, l2_rdata;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign set1 = addr_q[L1_BLOCK_LOG2 +: S1];
  assign tag1 = addr_q[ADDR_W-1 -: T1];
  assign set2 = l2addr_q[L2_BLOCK_LOG2 +: S2];
  assign tag2 = l2addr_q[ADDR_W-1 -: T2];
  assign blk  = {addr_q[ADDR_W-1:L2_BLOCK_LOG2], {L2_BLOCK_LOG2{1'b0}}};
  assign diff = {1'b0, blk} - {1'b0, last_q};

  // one way per cycle through the same comparators for either level
  always_comb begin
    if (state_q == S_L1_SCAN) begin
      cmp_tag_a = TW'(r1_tag[way_q[WW1-1:0]]);
      cmp_tag_b = TW'(tag1);
      cmp_st    = r1_st[way_q[WW1-1:0]];
      cmp_fl    = r1_fl[way_q[WW1-1:0]];
    end else begin
      cmp_tag_a = TW'(r2_tag[way_q[WW2-1:0]]);
      cmp_tag_b = TW'(tag2);
      cmp_st    = r2_st[way_q[WW2-1:0]];
      cmp_fl    = r2_fl[way_q[WW2-1:0]][1:0];
    end
    tag_eq     = (cmp_tag_a == cmp_tag_b);
    st_lt_best = (cmp_st < best_st_q);
    st_lt_min  = (cmp_st != '0) && ((minnz_q == '0) || (cmp_st < minnz_q));
  end

  always_comb begin
    for (int w = 0; w < L1_WAYS; w++) begin
      l1_wdata[w*W1 +: W1] = {r1_tag[w], r1_fl[w], r1_st[w]};
    end
    for (int w = 0; w < L2_WAYS; w++) begin
      l2_wdata[w*W2 +: W2] = {r2_tag[w], r2_fl[w], r2_st[w]};
    end
    if (state_q == S_CLEAR) begin
      l1_wdata = '0;
      l2_wdata = '0;
    end
  end

  assign l1_we    = ((state_q == S_CLEAR) && ((clr_q >> S1) == '0)) || (state_q == S_L1_WR);
  assign l1_waddr = (state_q == S_CLEAR) ? clr_q[S1-1:0] : set1;
  assign l2_we    = (state_q == S_CLEAR) || ((state_q == S_L2_WR) && wen_q);
  assign l2_waddr = (state_q == S_CLEAR) ? clr_q[S2-1:0] : set2;
  assign l2_re    = (state_q == S_L2_RD);

  tlcsp_ram #(.Width(W1 * L1_WAYS), .Depth(L1_SETS)) u_l1_ram (
    .clk_i   (clk_i),
    .we_i    (l1_we),
    .waddr_i (l1_waddr),
    .wdata_i (l1_wdata),
    .re_i    (accept),
    .raddr_i (address_i[L1_BLOCK_LOG2 +: S1]),
    .rdata_o (l1_rdata)
  );

  tlcsp_ram #(.Width(W2 * L2_WAYS), .Depth(L2_SETS)) u_l2_ram (
    .clk_i   (clk_i),
    .we_i    (l2_we),
    .waddr_i (l2_waddr),
    .wdata_i (l2_wdata),
    .re_i    (l2_re),
    .raddr_i (set2),
    .rdata_o (l2_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      after_q        <= S_DONE;
      op_q           <= OP_DEMAND;
      nxt_op_q       <= OP_DEMAND;
      clr_q          <= '0;
      degree_q       <= DEG_RESET;
      cnt_q          <= '0;
      last_q         <= '0;
      miss_seen_q    <= 1'b0;
      stride_known_q <= 1'b0;
      stride_q       <= '0;
      out_valid_q    <= 1'b0;
      wen_q          <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        degree_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CW'(CLR_N - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            wr_q      <= command_i;
            addr_q    <= address_i;
            cnt_q     <= cnt_q + 1'b1;
            res_l1_q  <= 1'b0;
            res_l2_q  <= 1'b0;
            res_use_q <= 1'b0;
            res_wb_q  <= '0;
            res_pf_q  <= '0;
            state_q   <= S_L1_LD;
          end
        end

        S_L1_LD: begin
          for (int w = 0; w < L1_WAYS; w++) begin
            {r1_tag[w], r1_fl[w], r1_st[w]} <= l1_rdata[w*W1 +: W1];
          end
          way_q   <= '0;
          hit_q   <= 1'b0;
          emp_q   <= 1'b0;
          state_q <= S_L1_SCAN;
        end

        S_L1_SCAN, S_L2_SCAN: begin
          if (cmp_fl[F_VALID] && tag_eq) begin
            hit_q  <= 1'b1;
            hitw_q <= way_q;
          end else if (!cmp_fl[F_VALID]) begin
            emp_q  <= 1'b1;
            empw_q <= way_q;
          end
          // lru: smallest stamp, lowest way on a tie
          if (way_q == '0 || st_lt_best) begin
            bestw_q      <= way_q;
            best_st_q    <= cmp_st;
            best_tag_q   <= cmp_tag_a;
            best_dirty_q <= cmp_fl[F_DIRTY];
          end
          if (way_q == '0) begin
            minnz_q <= cmp_st;
          end else if (st_lt_min) begin
            minnz_q <= cmp_st;
          end
          way_q <= way_q + 1'b1;
          if (state_q == S_L1_SCAN) begin
            if (way_q == WW'(L1_WAYS - 1)) state_q <= S_L1_UPD;
          end else begin
            if (way_q == WW'(L2_WAYS - 1)) state_q <= S_L2_UPD;
          end
        end

        S_L1_UPD: begin
          if (hit_q) begin
            r1_st[hitw_q[WW1-1:0]] <= cnt_q;
            if (wr_q) r1_fl[hitw_q[WW1-1:0]][F_DIRTY] <= 1'b1;
            res_l1_q <= 1'b1;
            after_q  <= S_DONE;
          end else begin
            if (emp_q) begin
              r1_tag[empw_q[WW1-1:0]] <= tag1;
              r1_fl[empw_q[WW1-1:0]]  <= {wr_q, 1'b1};
              r1_st[empw_q[WW1-1:0]]  <= cnt_q;
            end else begin
              r1_tag[bestw_q[WW1-1:0]] <= tag1;
              r1_fl[bestw_q[WW1-1:0]]  <= {wr_q, 1'b1};
              r1_st[bestw_q[WW1-1:0]]  <= cnt_q;
            end
            after_q <= S_L2_RD;
            if (!emp_q && best_dirty_q) begin
              // dirty victim goes to l2 first
              l2addr_q <= {best_tag_q[T1-1:0], set1, {L1_BLOCK_LOG2{1'b0}}};
              op_q     <= OP_VICTIM;
            end else begin
              l2addr_q <= addr_q;
              op_q     <= OP_DEMAND;
            end
          end
          state_q <= S_L1_WR;
        end

        S_L1_WR: begin
          state_q <= after_q;
        end

        S_L2_RD: begin
          state_q <= S_L2_LD;
        end

        S_L2_LD: begin
          for (int w = 0; w < L2_WAYS; w++) begin
            {r2_tag[w], r2_fl[w], r2_st[w]} <= l2_rdata[w*W2 +: W2];
          end
          way_q   <= '0;
          hit_q   <= 1'b0;
          emp_q   <= 1'b0;
          state_q <= S_L2_SCAN;
        end

        S_L2_UPD: begin
          wen_q   <= 1'b0;
          after_q <= S_DONE;
          case (op_q)
            OP_VICTIM: begin
              if (hit_q) begin
                r2_fl[hitw_q[WW2-1:0]][F_DIRTY] <= 1'b1;
                wen_q <= 1'b1;
              end else begin
                res_wb_q <= res_wb_q + 1'b1;
              end
              nxt_addr_q <= addr_q;
              nxt_op_q   <= OP_DEMAND;
              after_q    <= S_L2_RD;
            end
            OP_DEMAND: begin
              wen_q <= 1'b1;
              if (hit_q) begin
                res_l2_q <= 1'b1;
                if (r2_fl[hitw_q[WW2-1:0]][F_PREF]) begin
                  res_use_q <= 1'b1;
                  r2_fl[hitw_q[WW2-1:0]][F_PREF] <= 1'b0;
                end
                r2_st[hitw_q[WW2-1:0]] <= cnt_q;
              end else begin
                if (emp_q) begin
                  r2_tag[empw_q[WW2-1:0]] <= tag2;
                  r2_fl[empw_q[WW2-1:0]]  <= 3'b001;
                  r2_st[empw_q[WW2-1:0]]  <= cnt_q;
                end else begin
                  if (best_dirty_q) res_wb_q <= res_wb_q + 1'b1;
                  r2_tag[bestw_q[WW2-1:0]] <= tag2;
                  r2_fl[bestw_q[WW2-1:0]]  <= 3'b001;
                  r2_st[bestw_q[WW2-1:0]]  <= cnt_q;
                end
                // stride detector on the l2 block address
                if (!miss_seen_q) begin
                  miss_seen_q <= 1'b1;
                end else if (!stride_known_q) begin
                  stride_q       <= diff;
                  stride_known_q <= 1'b1;
                end else if (diff == stride_q) begin
                  if (degree_q != '0) begin
                    pf_left_q  <= degree_q;
                    nxt_addr_q <= blk + stride_q[ADDR_W-1:0];
                    nxt_op_q   <= OP_PREF;
                    after_q    <= S_L2_RD;
                  end
                end else begin
                  stride_q <= diff;
                end
                last_q <= blk;
              end
            end
            OP_PREF: begin
              if (!hit_q) begin
                wen_q    <= 1'b1;
                res_pf_q <= res_pf_q + 1'b1;
                if (emp_q) begin
                  r2_tag[empw_q[WW2-1:0]] <= tag2;
                  r2_fl[empw_q[WW2-1:0]]  <= 3'b101;
                  r2_st[empw_q[WW2-1:0]]  <= (minnz_q == '0) ? '0 : minnz_q - 1'b1;
                end else begin
                  if (best_dirty_q) res_wb_q <= res_wb_q + 1'b1;
                  r2_tag[bestw_q[WW2-1:0]] <= tag2;
                  r2_fl[bestw_q[WW2-1:0]]  <= 3'b101;
                  r2_st[bestw_q[WW2-1:0]]  <= (minnz_q == '0) ? '0 : minnz_q - 1'b1;
                end
              end
              pf_left_q  <= pf_left_q - 1'b1;
              nxt_addr_q <= l2addr_q + stride_q[ADDR_W-1:0];
              nxt_op_q   <= OP_PREF;
              if (pf_left_q != DEG_W'(1)) after_q <= S_L2_RD;
            end
            default: begin
              after_q <= S_DONE;
            end
          endcase
          state_q <= S_L2_WR;
        end

        S_L2_WR: begin
          l2addr_q <= nxt_addr_q;
          op_q     <= nxt_op_q;
          state_q  <= after_q;
        end

        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            o_l1_q      <= res_l1_q;
            o_l2_q      <= res_l2_q;
            o_use_q     <= res_use_q;
            o_wb_q      <= res_wb_q;
            o_pf_q      <= res_pf_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign l1_hit_o          = o_l1_q;
  assign l2_hit_o          = o_l2_q;
  assign prefetch_useful_o = o_use_q;
  assign wb_count_o        = o_wb_q;
  assign pf_count_o        = o_pf_q;

endmodule

>>> rtl/tlcsp_ram.sv
// ----------------------------------------------------------------------------
// tlcsp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tlcsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
